// ----- src/flg_pkg.sv -----
// Shared types, register indexes and helpers for the stereo flanger.
package flg_pkg;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_RATE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIX      = 2'd3;

    localparam logic [7:0] RATE_RST     = 8'd25;
    localparam logic [7:0] DEPTH_RST    = 8'd180;
    localparam logic [7:0] FEEDBACK_RST = 8'd100;
    localparam logic [7:0] MIX_RST      = 8'd150;

    localparam logic [31:0] RIGHT_PHASE_RST = 32'h4000_0000;

    typedef struct packed {
        logic signed [15:0] left_in;
        logic signed [15:0] right_in;
    } flg_in_t;

    typedef struct packed {
        logic signed [15:0] left_out;
        logic signed [15:0] right_out;
    } flg_out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_XX,
        ST_C2,
        ST_T1,
        ST_T2,
        ST_U,
        ST_DLY,
        ST_RDA,
        ST_RDB,
        ST_IA,
        ST_IB,
        ST_WET,
        ST_WR,
        ST_MIX,
        ST_OUT,
        ST_DONE
    } flg_state_t;

    typedef struct packed {
        flg_state_t step;
        logic       ch;
        logic       accept;
        logic       commit;
    } flg_cmd_t;

    function automatic logic signed [15:0] sat16(input logic signed [23:0] v);
        logic signed [15:0] r;
        if (v > 24'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -24'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

// ----- src/stereo_flanger.sv -----
// Stereo flanger top level: controller plus datapath.
//
// Input channel s_valid/s_ready/s_data carries one stereo Q1.15 frame per
// transfer; output channel m_valid/m_ready/m_data returns one mixed frame.
// Configuration: cfg_we, cfg_index (0 rate, 1 depth, 2 feedback, 3 mix) and
// cfg_data; the user must write them only while no frame is in flight, as the block itself does not enforce it.
// One shared 18x18 multiplier serves 10 of the 14 steps per channel, left then
// right; a new frame is taken only once the previous one has committed to the
// output register.
// The delay rings are single-port memories with a registered read; a fill
// flag and the write pointer mark which slots hold written data, so no
// clearing pass runs after reset.
// Reset (aresetn low, synchronous) restores the register defaults, the LFO
// phases and the write pointer, and empties the output register.
// A waiting result stays in the output register; the next frame is still
// taken and processed, and holds before commit until m_ready frees the slot.
module stereo_flanger
    import flg_pkg::*;
#(
    parameter int DELAY_DEPTH    = 1024,
    parameter int SAMPLE_RATE_HZ = 44100
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  flg_in_t               s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output flg_out_t              m_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    flg_cmd_t cmd;

    flg_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    flg_datapath #(
        .DELAY_DEPTH    (DELAY_DEPTH),
        .SAMPLE_RATE_HZ (SAMPLE_RATE_HZ)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .s_data    (s_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_data    (m_data)
    );

endmodule

// ----- src/flg_ctrl.sv -----
// Sequencing controller for the stereo flanger: handshakes and step order.
module flg_ctrl
    import flg_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    output flg_cmd_t cmd
);

    flg_state_t state_reg, state_next;
    logic       ch_reg, ch_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            ch_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ch_reg      <= ch_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        ch_next    = ch_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_XX;
                    ch_next    = 1'b0;
                end
            end
            ST_XX:  state_next = ST_C2;
            ST_C2:  state_next = ST_T1;
            ST_T1:  state_next = ST_T2;
            ST_T2:  state_next = ST_U;
            ST_U:   state_next = ST_DLY;
            ST_DLY: state_next = ST_RDA;
            ST_RDA: state_next = ST_RDB;
            ST_RDB: state_next = ST_IA;
            ST_IA:  state_next = ST_IB;
            ST_IB:  state_next = ST_WET;
            ST_WET: state_next = ST_WR;
            ST_WR:  state_next = ST_MIX;
            ST_MIX: state_next = ST_OUT;
            ST_OUT: begin
                if (ch_reg) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_XX;
                    ch_next    = 1'b1;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready    = (state_reg == ST_IDLE);
        cmd.step   = state_reg;
        cmd.ch     = ch_reg;
        cmd.accept = (state_reg == ST_IDLE) && s_valid;
        cmd.commit = (state_reg == ST_DONE) && out_free;
        m_valid_next = m_valid_reg;
        if (cmd.commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
        m_valid = m_valid_reg;
    end

`ifndef SYNTHESIS
    a_commit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> m_valid_reg)
        else $error("result not presented after commit");
    a_accept_start: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept |=> (state_reg == ST_XX) && !ch_reg)
        else $error("frame did not start on the left channel");
    a_right_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT) && ch_reg |=> state_reg == ST_DONE)
        else $error("right channel not followed by commit");
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !cmd.commit)
        else $error("accept and commit overlap");
`endif

endmodule

// ----- src/flg_datapath.sv -----
// Datapath for the stereo flanger: coefficients, LFOs, delay rings and shared multiplier.
module flg_datapath
    import flg_pkg::*;
#(
    parameter int DELAY_DEPTH    = 1024,
    parameter int SAMPLE_RATE_HZ = 44100
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  flg_cmd_t              cmd,
    input  flg_in_t               s_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output flg_out_t              m_data
);

    localparam int AW    = $clog2(DELAY_DEPTH);
    localparam int DLY_W = AW + 8;
    localparam int DMIN  = (SAMPLE_RATE_HZ * 16) / 125;
    localparam int SPAN  = (SAMPLE_RATE_HZ * 144) / 125;
    localparam int DCAP  = (DELAY_DEPTH - 2) * 256;
    localparam logic [63:0] INC_DEN = 64'(25500) * 64'(SAMPLE_RATE_HZ);

    typedef logic [31:0] inc_tab_t [256];

    function automatic inc_tab_t build_inc();
        inc_tab_t    tab;
        logic [63:0] num;
        for (int i = 0; i < 256; i++) begin
            num    = 64'(1275 + 395 * i) << 32;
            tab[i] = 32'(num / INC_DEN);
        end
        return tab;
    endfunction

    localparam inc_tab_t INC_TAB = build_inc();

    // configuration and derived coefficients
    logic [7:0]  rate_code_reg, depth_code_reg, fb_code_reg, mix_code_reg;
    logic [16:0] depth_reg, mix_reg;
    logic [15:0] fb_base_reg, fb_reg;
    logic [13:0] fb_v_reg;
    logic [16:0] span_q_reg;
    logic [31:0] inc_reg;
    logic [21:0] fb_v257;
    logic [5:0]  fb_q0;
    logic [13:0] fb_r;
    logic [33:0] span_prod;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_code_reg  <= RATE_RST;
            depth_code_reg <= DEPTH_RST;
            fb_code_reg    <= FEEDBACK_RST;
            mix_code_reg   <= MIX_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_RATE:     rate_code_reg  <= cfg_data;
                REG_DEPTH:    depth_code_reg <= cfg_data;
                REG_FEEDBACK: fb_code_reg    <= cfg_data;
                REG_MIX:      mix_code_reg   <= cfg_data;
                default:      ;
            endcase
        end
    end

    always_comb begin
        fb_v257   = {fb_v_reg, 8'd0} + 22'(fb_v_reg);
        fb_q0     = fb_v257[21:16];
        fb_r      = fb_v_reg - (14'({fb_q0, 8'd0}) - 14'(fb_q0));
        span_prod = 34'(SPAN) * 34'(depth_reg);
    end

    always_ff @(posedge aclk) begin
        depth_reg   <= {1'b0, depth_code_reg, 8'd0} + 17'(depth_code_reg)
                       + 17'(depth_code_reg[7]);
        mix_reg     <= {1'b0, mix_code_reg, 8'd0} + 17'(mix_code_reg)
                       + 17'(mix_code_reg[7]);
        fb_base_reg <= {fb_code_reg, 8'd0} - 16'({fb_code_reg, 4'd0})
                       + 16'({fb_code_reg, 2'd0});
        fb_v_reg    <= 14'({fb_code_reg, 5'd0}) + 14'({fb_code_reg, 3'd0})
                       - 14'(fb_code_reg) + 14'd127;
        fb_reg      <= fb_base_reg + 16'(fb_q0) + 16'(fb_r >= 14'd255);
        span_q_reg  <= span_prod[32:16];
        inc_reg     <= INC_TAB[rate_code_reg];
    end

    // frame state
    flg_in_t            in_reg;
    logic [AW-1:0]      wp_reg;
    logic               full_reg;
    logic [31:0]        ph_l_reg, ph_r_reg;
    logic signed [15:0] res_l_reg, res_r_reg;
    flg_out_t           m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg   <= '0;
            full_reg <= 1'b0;
            ph_l_reg <= '0;
            ph_r_reg <= RIGHT_PHASE_RST;
        end else if (cmd.commit) begin
            if (wp_reg == AW'(DELAY_DEPTH - 1)) begin
                wp_reg   <= '0;
                full_reg <= 1'b1;
            end else begin
                wp_reg <= wp_reg + 1'b1;
            end
            ph_l_reg <= ph_l_reg + inc_reg;
            ph_r_reg <= ph_r_reg + inc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            in_reg <= s_data;
        end
        if (cmd.commit) begin
            m_data_reg.left_out  <= res_l_reg;
            m_data_reg.right_out <= res_r_reg;
        end
    end

    assign m_data = m_data_reg;

    // per-channel working signals
    logic [31:0]        ph;
    logic [1:0]         quad;
    logic [14:0]        x_c;
    logic [14:0]        x_reg, x2_reg;
    logic signed [35:0] prod_reg, prod_next, mult;
    logic signed [17:0] op_a, op_b;
    logic [17:0]        sh14, s_cap, u_c;
    logic [20:0]        dsum;
    logic [DLY_W-1:0]   delay_c, delay_reg;
    logic [AW-1:0]      d_int, ia, ib, rd_addr;
    logic [7:0]         frac;
    logic [AW:0]        ia_w;
    logic               rd_en, vld_c, vld_reg;
    logic signed [15:0] rd_l_reg, rd_r_reg, rd_ch, a_reg, b_c, wet_c, wet_reg, in_ch;
    logic signed [35:0] rnd8, rnd16;
    logic signed [15:0] wr_data, out_c;

    logic signed [15:0] mem_l [DELAY_DEPTH];
    logic signed [15:0] mem_r [DELAY_DEPTH];

    assign ph    = cmd.ch ? ph_r_reg : ph_l_reg;
    assign quad  = ph[31:30];
    assign x_c   = quad[0] ? (15'd16384 - {1'b0, ph[29:16]}) : {1'b0, ph[29:16]};
    assign sh14  = prod_reg[31:14];
    assign s_cap = (sh14 > 18'd32768) ? 18'd32768 : sh14;
    assign u_c   = quad[1] ? (18'd32768 - s_cap) : (18'd32768 + s_cap);
    assign dsum  = 21'(DMIN) + 21'(prod_reg[33:16]);
    assign delay_c = (dsum > 21'(DCAP)) ? DLY_W'(DCAP) : dsum[DLY_W-1:0];
    assign d_int = delay_reg[DLY_W-1:8];
    assign frac  = delay_reg[7:0];
    assign ia_w  = {1'b0, wp_reg} - {1'b0, d_int}
                   + ((wp_reg < d_int) ? (AW+1)'(DELAY_DEPTH) : '0);
    assign ia    = ia_w[AW-1:0];
    assign ib    = (ia == '0) ? AW'(DELAY_DEPTH - 1) : ia - 1'b1;
    assign rd_addr = (cmd.step == ST_RDA) ? ia : ib;
    assign rd_en = (cmd.step == ST_RDA) || (cmd.step == ST_RDB);
    assign vld_c = full_reg || (rd_addr < wp_reg);
    assign rd_ch = cmd.ch ? rd_r_reg : rd_l_reg;
    assign b_c   = vld_reg ? rd_ch : '0;
    assign in_ch = cmd.ch ? in_reg.right_in : in_reg.left_in;
    assign rnd8  = prod_reg + 36'sd128;
    assign rnd16 = prod_reg + 36'sd32768;
    assign wet_c = rnd8[23:8];
    assign wr_data = sat16(24'(in_ch) + 24'($signed(rnd16[35:16])));
    assign out_c = sat16(24'($signed(rnd16[35:16])));
    assign mult  = op_a * op_b;

    always_comb begin
        op_a = '0;
        op_b = '0;
        prod_next = mult;
        unique case (cmd.step)
            ST_XX: begin
                op_a = 18'(x_c);
                op_b = 18'(x_c);
            end
            ST_C2: begin
                op_a = 18'sd2383;
                op_b = $signed(sh14);
            end
            ST_T1: begin
                op_a = 18'sd21077 - $signed(sh14);
                op_b = 18'(x2_reg);
            end
            ST_T2: begin
                op_a = 18'sd51466 - $signed(sh14);
                op_b = 18'(x_reg);
            end
            ST_U: begin
                op_a = $signed(u_c);
                op_b = 18'(span_q_reg);
            end
            ST_IA: begin
                op_a = 18'(a_reg);
                op_b = 18'sd256 - 18'(frac);
            end
            ST_IB: begin
                op_a = 18'(b_c);
                op_b = 18'(frac);
                prod_next = mult + prod_reg;
            end
            ST_WET: begin
                op_a = 18'(wet_c);
                op_b = 18'(fb_reg);
            end
            ST_WR: begin
                op_a = 18'(in_ch);
                op_b = 18'sd65536 - 18'(mix_reg);
            end
            ST_MIX: begin
                op_a = 18'(wet_reg);
                op_b = 18'(mix_reg);
                prod_next = mult + prod_reg;
            end
            default: prod_next = prod_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        if (cmd.step == ST_XX) begin
            x_reg <= x_c;
        end
        if (cmd.step == ST_C2) begin
            x2_reg <= sh14[14:0];
        end
        if (cmd.step == ST_DLY) begin
            delay_reg <= delay_c;
        end
        if (cmd.step == ST_RDB) begin
            a_reg <= vld_reg ? rd_ch : '0;
        end
        if (cmd.step == ST_WET) begin
            wet_reg <= wet_c;
        end
        if (cmd.step == ST_OUT) begin
            if (cmd.ch) begin
                res_r_reg <= out_c;
            end else begin
                res_l_reg <= out_c;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_l_reg <= mem_l[rd_addr];
            rd_r_reg <= mem_r[rd_addr];
            vld_reg  <= vld_c;
        end
        if ((cmd.step == ST_WR) && !cmd.ch) begin
            mem_l[wp_reg] <= wr_data;
        end
        if ((cmd.step == ST_WR) && cmd.ch) begin
            mem_r[wp_reg] <= wr_data;
        end
    end

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for the stereo flanger: directed table, random frames, stall pressure.
module tb_top;
    import flg_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING = 1024;
    localparam int FS = 44100;
    localparam int N_RANDOM = 1750;
    localparam longint CYCLE_LIMIT = 1500000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    flg_in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    flg_out_t m_data;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    stereo_flanger DUT (.*);

    always #10 aclk = ~aclk;

    // predictor state
    logic signed [15:0] ring_l [RING];
    logic signed [15:0] ring_r [RING];
    int unsigned wr_pos;
    logic [31:0] phase_l, phase_r;
    logic [7:0] rate_r, depth_r, fb_r, mix_r;

    flg_out_t frames_due[$];
    int errors = 0;
    longint cycles = 0;
    bit hold_off = 1'b0;
    bit stim_done = 1'b0;
    int n_out = 0;

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d want %0d (frame %0d)", what, got, want, n_out);
        errors++;
    endtask

    function automatic longint rnd_shift(input longint v, input int n);
        longint t;
        t = v + (longint'(1) <<< (n - 1));
        return t >>> n;
    endfunction

    function automatic longint clip16(input longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic longint sweep_level(input logic [31:0] ph);
        longint a, quad, f, x, x2, t, s;
        a = ph >> 16;
        quad = (a >> 14) & 3;
        f = a & 16'h3FFF;
        x = quad[0] ? 16384 - f : f;
        x2 = (x * x) >> 14;
        t = 21077 - ((2383 * x2) >> 14);
        t = 51466 - ((t * x2) >> 14);
        s = (t * x) >> 14;
        if (s > 32768) s = 32768;
        return quad[1] ? 32768 - s : 32768 + s;
    endfunction

    function automatic logic signed [15:0] flange_channel(
        ref logic signed [15:0] line [RING], input logic [31:0] ph,
        input longint x, input longint span_q, input longint fb, input longint mix);
        longint dly, d, fr, ia, ib, wet, mixed;
        dly = (FS * 16) / 125 + ((sweep_level(ph) * span_q) >> 16);
        if (dly > (RING - 2) * 256) dly = (RING - 2) * 256;
        d = dly >> 8;
        fr = dly & 255;
        ia = (wr_pos + RING - d) % RING;
        ib = (wr_pos + 2 * RING - d - 1) % RING;
        wet = rnd_shift(longint'(line[ia]) * (256 - fr) + longint'(line[ib]) * fr, 8);
        line[wr_pos] = 16'(clip16(x + rnd_shift(wet * fb, 16)));
        mixed = x * (65536 - mix) + wet * mix;
        return 16'(clip16(rnd_shift(mixed, 16)));
    endfunction

    function automatic flg_out_t flange_frame(input flg_in_t fin);
        longint dep, mix, fb, span_q, inc;
        flg_out_t r;
        dep = (longint'(depth_r) * 65536 + 127) / 255;
        mix = (longint'(mix_r) * 65536 + 127) / 255;
        fb = (longint'(fb_r) * 62259 + 127) / 255;
        span_q = (((FS * 144) / 125) * dep) >> 16;
        inc = ((1275 + 395 * longint'(rate_r)) << 32) / (25500 * longint'(FS));
        r.left_out = flange_channel(ring_l, phase_l, fin.left_in, span_q, fb, mix);
        r.right_out = flange_channel(ring_r, phase_r, fin.right_in, span_q, fb, mix);
        wr_pos = (wr_pos + 1) % RING;
        phase_l += 32'(inc);
        phase_r += 32'(inc);
        return r;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_RATE:     rate_r = val;
            REG_DEPTH:    depth_r = val;
            REG_FEEDBACK: fb_r = val;
            default:      mix_r = val;
        endcase
    endtask

    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (frames_due.size() != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
    endtask

    // valid stays high after a transfer until the next negedge decides the gap
    task automatic send_frame(input flg_in_t fin);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= fin;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        frames_due.push_back(flange_frame(fin));
    endtask

    // directed rows: input frame, and a fixed expectation where obvious
    typedef struct {
        flg_in_t fin;
        bit fixed;
        flg_out_t want;
    } row_t;

    row_t rows[$];

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("** stereo_flanger: FAILED **");
            $finish;
        end
        if (aresetn && m_valid && m_ready) begin
            if (frames_due.size() == 0) begin
                report("unexpected transfer", 0, 0);
            end else begin
                flg_out_t w;
                w = frames_due.pop_front();
                if (m_data.left_out !== w.left_out)
                    report("left_out", m_data.left_out, w.left_out);
                if (m_data.right_out !== w.right_out)
                    report("right_out", m_data.right_out, w.right_out);
            end
            n_out++;
        end
    end

    // receiver: random stalls, with occasional long hold-offs
    initial begin
        int gap;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_off) begin
                m_ready <= 1'b0;
            end else begin
                gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
                if (gap > 0) begin
                    m_ready <= 1'b0;
                    repeat (gap) @(negedge aclk);
                end
                m_ready <= 1'b1;
                @(posedge aclk);
                while (!(m_valid && m_ready)) @(posedge aclk);
            end
        end
    end

    initial begin
        flg_in_t fin;
        row_t rw;
        logic [7:0] set_vals[4];
        set_vals = '{8'd0, 8'd255, 8'd1, 8'd128};
        foreach (ring_l[i]) begin
            ring_l[i] = '0;
            ring_r[i] = '0;
        end
        wr_pos = 0;
        phase_l = '0;
        phase_r = RIGHT_PHASE_RST;
        rate_r = RATE_RST;
        depth_r = DEPTH_RST;
        fb_r = FEEDBACK_RST;
        mix_r = MIX_RST;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // rings empty after reset: the wet path reads zero, so output is the dry share
        rw.fin = '{left_in: 16'sd0, right_in: 16'sd0};
        rw.fixed = 1'b1;
        rw.want = '0;
        rows.push_back(rw);
        rw.fixed = 1'b0;
        rw.fin = '{left_in: 16'sh7FFF, right_in: 16'sh8000}; rows.push_back(rw);
        rw.fin = '{left_in: 16'sh8000, right_in: 16'sh7FFF}; rows.push_back(rw);
        rw.fin = '{left_in: -16'sd1, right_in: 16'sd1};       rows.push_back(rw);
        rw.fin = '{left_in: 16'sh5555, right_in: 16'shAAAA}; rows.push_back(rw);
        foreach (rows[i]) begin
            send_frame(rows[i].fin);
            if (rows[i].fixed) frames_due[$] = rows[i].want;
        end
        drain();

        // full feedback and full wet with deep sweep; the longest delay stays below the ring end
        write_reg(REG_RATE, 8'd255);
        write_reg(REG_DEPTH, 8'd255);
        write_reg(REG_FEEDBACK, 8'd255);
        write_reg(REG_MIX, 8'd255);
        repeat (10) begin
            fin.left_in = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            fin.right_in = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            send_frame(fin);
        end
        drain();
        write_reg(REG_RATE, 8'd0);
        write_reg(REG_DEPTH, 8'd0);
        write_reg(REG_FEEDBACK, 8'd0);
        write_reg(REG_MIX, 8'd0);
        repeat (8) send_frame(flg_in_t'($urandom));
        drain();

        // pressure: receiver holds off while frames keep coming
        fork
            begin
                hold_off = 1'b1;
                repeat (400) @(negedge aclk);
                hold_off = 1'b0;
            end
            repeat (20) send_frame(flg_in_t'($urandom));
        join

        for (int p = 0; p < 5; p++) begin
            drain();
            write_reg(REG_RATE, p < 4 ? set_vals[p] : 8'($urandom));
            write_reg(REG_DEPTH, 8'($urandom));
            write_reg(REG_FEEDBACK, p < 4 ? set_vals[3 - p] : 8'($urandom));
            write_reg(REG_MIX, 8'($urandom));
            for (int k = 0; k < N_RANDOM / 5; k++) begin
                case ($urandom_range(0, 5))
                    0: fin = '{left_in: 16'sh7FFF, right_in: 16'sh8000};
                    1: fin = '{left_in: 16'(signed'($urandom_range(0, 64)) - 32),
                               right_in: 16'(signed'($urandom_range(0, 64)) - 32)};
                    default: fin = flg_in_t'($urandom);
                endcase
                send_frame(fin);
            end
        end
        stim_done = 1'b1;
        drain();
        if (errors == 0) begin
            $display("** stereo_flanger: PASSED **");
        end else begin
            $display("** stereo_flanger: FAILED **");
        end
        $finish;
    end

endmodule
